// ----- rtl/deq_pkg.sv -----
package deq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_PEEK_HEAD = 3'd4,
      OP_PEEK_TAIL = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Slot that lies off positions after head, wrapped into the ring (off < DEPTH).
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(off[IDX_W-1:0]);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

// ----- rtl/double_ended_queue.sv -----
// Bounded double-ended queue of signed 32-bit entries kept in a ring buffer
// of DEPTH slots held in one synchronous RAM.
//
// Request channel: an operation code and a value are taken on the rising edge
// where start is high and busy is low. Operations: push head/tail, pop
// head/tail, peek head/tail, search.
// Response channel: exactly one beat per request, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so the beat must be taken then.
//
// Pushes, pops, rejected operations and a search of an empty queue answer
// in the cycle after acceptance and keep busy low, so one such request may
// enter every cycle. A peek holds busy high while the RAM's registered read
// passes into the response register. A search streams one entry per cycle
// out of the RAM read port while busy is high; it compares from one entry
// up to as many as the queue holds.
//
// Reset (synchronous, active high) empties the queue and returns to idle; the
// RAM contents are not cleared, since only written slots are ever read.
module double_ended_queue
   import deq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic                     rsp_found
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_PEEK = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [DATA_W-1:0] val_ff, val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_found_ff, rsp_found_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              full, empty;

   deq_ram #(
      .DATA_W  (DATA_W),
      .ENTRIES (DEPTH),
      .ADDR_W  (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign full  = (occ_ff == CNT_W'(DEPTH));
   assign empty = (occ_ff == '0);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      scan_in       = scan_ff;
      val_in        = val_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      rd_addr       = slot_at(head_ff, scan_ff);
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_found_in  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in = req_value;
               case (op_type'(req_operation))
                  OP_PUSH_HEAD: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        head_in = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = head_in;
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_PUSH_TAIL: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_at(head_ff, occ_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
                  OP_POP_HEAD: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        head_in = slot_at(head_ff, CNT_W'(1));
                        occ_in  = occ_ff - 1'b1;
                     end
                  end
                  OP_POP_TAIL: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
                  OP_PEEK_HEAD: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_addr  = head_ff;
                        state_in = S_PEEK;
                     end
                  end
                  OP_PEEK_TAIL: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rd_addr  = slot_at(head_ff, occ_ff - 1'b1);
                        state_in = S_PEEK;
                     end
                  end
                  OP_SEARCH: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr  = head_ff;
                        scan_in  = CNT_W'(1);
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_PEEK: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            // rd_data holds the entry at offset scan_ff - 1
            if (rd_data == val_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               state_in     = S_IDLE;
            end else if (scan_ff == occ_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;

endmodule

// ----- rtl/deq_ram.sv -----
module deq_ram #(
   parameter int DATA_W  = 32,
   parameter int ENTRIES = 16,
   parameter int ADDR_W  = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/deq_checker.sv -----
module deq_checker
   import deq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [1:0]               rsp_status,
   input logic signed [DATA_W-1:0] rsp_read_value,
   input logic                     rsp_found
);

   // an accepted request either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor pending");

   // leaving a multi-cycle operation delivers its beat
   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a response beat");

   // no beat while a multi-cycle operation is still pending
   a_no_beat_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy) && !$past(reset)) |-> !rsp_valid)
      else $error("response beat while still busy");

   // a rejected operation carries neither data nor a hit
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_read_value == '0) && !rsp_found))
      else $error("rejected operation returned data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_OK) || (rsp_status == ST_EMPTY)
                     || (rsp_status == ST_FULL)))
      else $error("response status out of range");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_found      (rsp_found)
);
